@@ design/ufcm_pkg.sv @@
// Shared constants and codes for the union-find component-minimum engine.
// No dependencies; the two interfaces and the top module import it, the RAM does not.
`timescale 1ns / 1ps

package ufcm_pkg;

    // Forest size and the index width that follows from it
    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // Request and result field widths
    localparam int OP_W    = 2;
    localparam int FIELD_W = 10;
    localparam int COST_W  = 32;
    localparam int SUM_W   = 42;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_UNION    = 2'd1,
        OP_QUERY    = 2'd2,
        OP_RESERVED = 2'd3
    } t_op;

endpackage

@@ design/ufcm_in_if.sv @@
// Request channel of the union-find engine: valid/ready plus request fields.
// Depends on ufcm_pkg for field widths.
`timescale 1ns / 1ps

interface ufcm_in_if;
    import ufcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [FIELD_W-1:0] first_node;
    logic [FIELD_W-1:0] second_node;
    logic [COST_W-1:0]  cost_value;

    modport source (
        output valid, operation, first_node, second_node, cost_value,
        input  ready
    );

    modport sink (
        input  valid, operation, first_node, second_node, cost_value,
        output ready
    );
endinterface

@@ design/ufcm_out_if.sv @@
// Result channel of the union-find engine: valid/ready plus result fields.
// Depends on ufcm_pkg for field widths.
`timescale 1ns / 1ps

interface ufcm_out_if;
    import ufcm_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_answer;
    logic [COST_W-1:0] component_minimum;
    logic [SUM_W-1:0]  running_total;

    modport source (
        output valid, is_answer, component_minimum, running_total,
        input  ready
    );

    modport sink (
        input  valid, is_answer, component_minimum, running_total,
        output ready
    );
endinterface

@@ design/ufcm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ufcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/union_find_component_minimum_top.sv @@
// Union-find engine with per-component minimum cost, run by a microcoded sequencer.
// Requests are handled one at a time: the next is taken only once the result of the last
// one is loaded into the output register. Finds use path halving.
// Reset (synchronous, active low) starts a clearing pass that writes each parent entry
// with its own index; no request is taken until it ends.
`timescale 1ns / 1ps

module union_find_component_minimum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufcm_in_if.sink     i_in,
    ufcm_out_if.source  o_out
);
    import ufcm_pkg::*;

    // ------------------------------------------------------------------
    // Microcode: step addresses, control fields and the program ROM
    // ------------------------------------------------------------------
    typedef enum logic [4:0] {
        S_EMIT    = 5'd0,   // must sit right before S_WAIT: falls through to it
        S_WAIT    = 5'd1,
        S_D_QUERY = 5'd2,
        S_D_UNION = 5'd3,
        S_D_LOAD  = 5'd4,
        S_ACK     = 5'd5,
        S_LOAD    = 5'd6,
        S_UNION   = 5'd7,
        S_UA_F0   = 5'd8,
        S_UA_F1   = 5'd9,
        S_UA_F2   = 5'd10,
        S_UA_DONE = 5'd11,
        S_UB_F0   = 5'd12,
        S_UB_F1   = 5'd13,
        S_UB_F2   = 5'd14,
        S_UB_DONE = 5'd15,
        S_U_LINK  = 5'd16,
        S_QUERY   = 5'd17,
        S_Q_F0    = 5'd18,
        S_Q_F1    = 5'd19,
        S_Q_F2    = 5'd20,
        S_Q_DONE  = 5'd21,
        S_Q_ACC   = 5'd22
    } t_step;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_NO_REQ, C_OP_QUERY, C_OP_UNION, C_OP_LOAD,
        C_ROOT, C_SAME, C_A_BAD, C_AB_BAD, C_OUT_FULL
    } t_cond;

    typedef enum logic {PRD_X, PRD_DATA} t_prd_sel;
    typedef enum logic [1:0] {PW_NONE, PW_HALVE, PW_LINK} t_pw_sel;
    typedef enum logic [1:0] {CW_NONE, CW_LOAD, CW_MIN} t_cw_sel;
    typedef enum logic [1:0] {X_HOLD, X_DATA, X_B} t_x_sel;

    typedef struct packed {
        logic     in_rdy;   // take a request (WAIT only)
        t_prd_sel prd_sel;  // parent read address
        t_pw_sel  pw_sel;   // parent write
        t_cw_sel  cw_sel;   // cost write
        t_x_sel   x_sel;    // walker update
        logic     ld_ra;    // hold first root
        logic     ld_ca;    // hold first root's cost
        logic     acc;      // take query answer, advance total
        logic     out_ld;   // load result register
        t_cond    cond;
        t_step    target;
    } t_ctrl;

    function automatic t_ctrl rom(input t_step step);
        t_ctrl c;
        c = '{in_rdy: 1'b0, prd_sel: PRD_X, pw_sel: PW_NONE, cw_sel: CW_NONE,
              x_sel: X_HOLD, ld_ra: 1'b0, ld_ca: 1'b0, acc: 1'b0, out_ld: 1'b0,
              cond: C_NEVER, target: S_EMIT};
        case (step)
            S_EMIT: begin
                c.out_ld = 1'b1;
                c.cond   = C_OUT_FULL;
                c.target = S_EMIT;
            end
            S_WAIT: begin
                c.in_rdy = 1'b1;
                c.cond   = C_NO_REQ;
                c.target = S_WAIT;
            end
            S_D_QUERY: begin c.cond = C_OP_QUERY; c.target = S_QUERY; end
            S_D_UNION: begin c.cond = C_OP_UNION; c.target = S_UNION; end
            S_D_LOAD:  begin c.cond = C_OP_LOAD;  c.target = S_LOAD;  end
            S_ACK:     begin c.cond = C_ALWAYS;   c.target = S_EMIT;  end
            S_LOAD: begin
                c.cw_sel = CW_LOAD;
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
            end
            S_UNION: begin c.cond = C_AB_BAD; c.target = S_EMIT; end
            S_UA_F0: begin c.prd_sel = PRD_X; end
            S_UA_F1: begin
                c.prd_sel = PRD_DATA;
                c.cond    = C_ROOT;
                c.target  = S_UA_DONE;
            end
            S_UA_F2: begin
                c.prd_sel = PRD_DATA;
                c.pw_sel  = PW_HALVE;
                c.x_sel   = X_DATA;
                c.cond    = C_ALWAYS;
                c.target  = S_UA_F1;
            end
            S_UA_DONE: begin
                c.ld_ra = 1'b1;
                c.x_sel = X_B;
            end
            S_UB_F0: begin
                c.prd_sel = PRD_X;
                c.ld_ca   = 1'b1;
            end
            S_UB_F1: begin
                c.prd_sel = PRD_DATA;
                c.cond    = C_ROOT;
                c.target  = S_UB_DONE;
            end
            S_UB_F2: begin
                c.prd_sel = PRD_DATA;
                c.pw_sel  = PW_HALVE;
                c.x_sel   = X_DATA;
                c.cond    = C_ALWAYS;
                c.target  = S_UB_F1;
            end
            S_UB_DONE: begin c.cond = C_SAME; c.target = S_EMIT; end
            S_U_LINK: begin
                c.pw_sel = PW_LINK;
                c.cw_sel = CW_MIN;
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
            end
            S_QUERY: begin c.cond = C_A_BAD; c.target = S_EMIT; end
            S_Q_F0: begin c.prd_sel = PRD_X; end
            S_Q_F1: begin
                c.prd_sel = PRD_DATA;
                c.cond    = C_ROOT;
                c.target  = S_Q_DONE;
            end
            S_Q_F2: begin
                c.prd_sel = PRD_DATA;
                c.pw_sel  = PW_HALVE;
                c.x_sel   = X_DATA;
                c.cond    = C_ALWAYS;
                c.target  = S_Q_F1;
            end
            S_Q_DONE: begin end
            S_Q_ACC: begin
                c.acc    = 1'b1;
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
            end
            default: begin
                c.cond   = C_ALWAYS;
                c.target = S_WAIT;
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_step              r_upc, n_upc;
    logic               r_clr_busy;
    logic [NODE_W-1:0]  r_clr_idx;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_sum;

    logic [OP_W-1:0]    r_op;
    logic [FIELD_W-1:0] r_a;
    logic [FIELD_W-1:0] r_b;
    logic [COST_W-1:0]  r_cost;
    logic [NODE_W-1:0]  r_x;        // node being walked
    logic [NODE_W-1:0]  r_ra;       // root of the first union node
    logic [COST_W-1:0]  r_ca;       // cost of that root
    logic               r_is_ans;
    logic [COST_W-1:0]  r_min;
    logic               r_out_is_ans;
    logic [COST_W-1:0]  r_out_min;
    logic [SUM_W-1:0]   r_out_sum;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    t_ctrl              w_ctrl;
    logic               w_accept;
    logic               w_out_full;
    logic               w_a_ok;
    logic               w_b_ok;
    logic               w_take;
    logic [NODE_W-1:0]  w_prd;
    logic [NODE_W-1:0]  w_praddr;
    logic               w_pwe;
    logic [NODE_W-1:0]  w_pwaddr;
    logic [NODE_W-1:0]  w_pwdata;
    logic [COST_W-1:0]  w_crd;
    logic               w_cwe;
    logic [NODE_W-1:0]  w_cwaddr;
    logic [COST_W-1:0]  w_cwdata;
    logic [SUM_W:0]     w_sum_ext;
    logic [SUM_W-1:0]   w_sum_sat;

    assign w_ctrl     = rom(r_upc);
    assign i_in.ready = w_ctrl.in_rdy && !r_clr_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_full = r_out_valid && !o_out.ready;

    assign w_a_ok = 32'(r_a) < NODE_COUNT;
    assign w_b_ok = 32'(r_b) < NODE_COUNT;

    // Parent RAM: the clearing pass owns the write port until it ends
    assign w_praddr = (w_ctrl.prd_sel == PRD_DATA) ? w_prd : r_x;

    always_comb begin
        w_pwe    = 1'b0;
        w_pwaddr = r_x;
        w_pwdata = w_prd;
        if (r_clr_busy) begin
            w_pwe    = 1'b1;
            w_pwaddr = r_clr_idx;
            w_pwdata = r_clr_idx;
        end else begin
            case (w_ctrl.pw_sel)
                PW_HALVE: begin
                    // point the walked node at its grandparent
                    w_pwe    = 1'b1;
                    w_pwaddr = r_x;
                    w_pwdata = w_prd;
                end
                PW_LINK: begin
                    // hang the first root under the second
                    w_pwe    = 1'b1;
                    w_pwaddr = r_ra;
                    w_pwdata = r_x;
                end
                default: begin
                    w_pwe = 1'b0;
                end
            endcase
        end
    end

    ufcm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (w_pwaddr),
        .i_wdata (w_pwdata),
        .i_raddr (w_praddr),
        .o_rdata (w_prd)
    );

    // Cost RAM: always read at the walker; the second root keeps the smaller cost
    always_comb begin
        w_cwe    = 1'b0;
        w_cwaddr = NODE_W'(r_a);
        w_cwdata = r_cost;
        case (w_ctrl.cw_sel)
            CW_LOAD: begin
                w_cwe    = w_a_ok;
                w_cwaddr = NODE_W'(r_a);
                w_cwdata = r_cost;
            end
            CW_MIN: begin
                w_cwe    = 1'b1;
                w_cwaddr = r_x;
                w_cwdata = (r_ca < w_crd) ? r_ca : w_crd;
            end
            default: begin
                w_cwe = 1'b0;
            end
        endcase
    end

    ufcm_ram #(
        .WIDTH (COST_W),
        .DEPTH (NODE_COUNT)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_raddr (r_x),
        .o_rdata (w_crd)
    );

    // Saturating running total
    assign w_sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(w_crd);
    assign w_sum_sat = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: jump to target when the condition holds, else advance
    // ------------------------------------------------------------------
    always_comb begin
        case (w_ctrl.cond)
            C_ALWAYS:   w_take = 1'b1;
            C_NO_REQ:   w_take = !w_accept;
            C_OP_QUERY: w_take = r_op == OP_QUERY;
            C_OP_UNION: w_take = r_op == OP_UNION;
            C_OP_LOAD:  w_take = r_op == OP_LOAD;
            C_ROOT:     w_take = w_prd == r_x;
            C_SAME:     w_take = r_x == r_ra;
            C_A_BAD:    w_take = !w_a_ok;
            C_AB_BAD:   w_take = !(w_a_ok && w_b_ok);
            C_OUT_FULL: w_take = w_out_full;
            default:    w_take = 1'b0;
        endcase
        n_upc = w_take ? w_ctrl.target : t_step'(r_upc + 5'd1);
    end

    // Control state, then payload registers, which need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= S_WAIT;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_upc <= n_upc;
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + NODE_W'(1);
                if (r_clr_idx == NODE_W'(NODE_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_ctrl.out_ld && !w_out_full) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctrl.acc) begin
                r_sum <= w_sum_sat;
            end
        end

        if (w_ctrl.in_rdy && w_accept) begin
            r_op     <= i_in.operation;
            r_a      <= i_in.first_node;
            r_b      <= i_in.second_node;
            r_cost   <= i_in.cost_value;
            r_x      <= NODE_W'(i_in.first_node);
            r_is_ans <= i_in.operation == OP_QUERY;
            r_min    <= '0;
        end else begin
            case (w_ctrl.x_sel)
                X_DATA:  r_x <= w_prd;
                X_B:     r_x <= NODE_W'(r_b);
                default: r_x <= r_x;
            endcase
        end
        if (w_ctrl.ld_ra) begin
            r_ra <= r_x;
        end
        if (w_ctrl.ld_ca) begin
            r_ca <= w_crd;
        end
        if (w_ctrl.acc) begin
            r_min <= w_crd;
        end
        if (w_ctrl.out_ld && !w_out_full) begin
            r_out_is_ans <= r_is_ans;
            r_out_min    <= r_min;
            r_out_sum    <= r_sum;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.is_answer         = r_out_is_ans;
    assign o_out.component_minimum = r_out_min;
    assign o_out.running_total     = r_out_sum;
endmodule
